@@ src/fss_pkg.sv @@
// Shared types and constants for the fan speed sleep timer.
// Item and result beat layouts, configuration register map and reset values.
// No dependencies.
`default_nettype none

package fss_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 8;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] REG_TICKS_PER_SECOND = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_HOURS        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_DUTY_LEVEL1      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_DUTY_LEVEL2      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_DUTY_LEVEL3      = 3'd4;

  // Register reset values
  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd5;
  localparam logic [2:0] MAX_HOURS_RST        = 3'd4;
  localparam logic [7:0] DUTY_LEVEL1_RST      = 8'd84;
  localparam logic [7:0] DUTY_LEVEL2_RST      = 8'd168;
  localparam logic [7:0] DUTY_LEVEL3_RST      = 8'd255;

  // Seconds per minute and minutes per hour
  localparam logic [5:0] UNITS_PER_NEXT = 6'd60;

  // Speed levels
  localparam logic [1:0] LEVEL_OFF = 2'd0;
  localparam logic [1:0] LEVEL_1   = 2'd1;
  localparam logic [1:0] LEVEL_2   = 2'd2;
  localparam logic [1:0] LEVEL_3   = 2'd3;

  typedef struct packed {
    logic tick;
    logic btn_power;
    logic btn_speed1;
    logic btn_speed2;
    logic btn_speed3;
    logic btn_timer;
  } item_t;

  typedef struct packed {
    logic       fan_on;
    logic [1:0] fan_level;
    logic [7:0] pwm_duty;
    logic [2:0] hours_left;
  } result_t;

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [2:0] max_hours;
    logic [7:0] duty_level1;
    logic [7:0] duty_level2;
    logic [7:0] duty_level3;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/fss_cfg.sv @@
// Configuration register file for the fan speed sleep timer.
// Decodes writes by index into the cfg_t struct; depends on fss_pkg.
`default_nettype none

module fss_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [fss_pkg::CfgIndexWidth-1:0] wr_index,
  input  wire logic [fss_pkg::CfgDataWidth-1:0]  wr_data,
  output fss_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= fss_pkg::TICKS_PER_SECOND_RST;
      cfg.max_hours        <= fss_pkg::MAX_HOURS_RST;
      cfg.duty_level1      <= fss_pkg::DUTY_LEVEL1_RST;
      cfg.duty_level2      <= fss_pkg::DUTY_LEVEL2_RST;
      cfg.duty_level3      <= fss_pkg::DUTY_LEVEL3_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        fss_pkg::REG_TICKS_PER_SECOND: cfg.ticks_per_second <= wr_data;
        fss_pkg::REG_MAX_HOURS:        cfg.max_hours        <= wr_data[2:0];
        fss_pkg::REG_DUTY_LEVEL1:      cfg.duty_level1      <= wr_data;
        fss_pkg::REG_DUTY_LEVEL2:      cfg.duty_level2      <= wr_data;
        fss_pkg::REG_DUTY_LEVEL3:      cfg.duty_level3      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/fss_core.sv @@
// Controller state and its one-item update: sleep timer chain, power toggle,
// speed select, timer button and duty lookup. Depends on fss_pkg.
`default_nettype none

module fss_core (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire fss_pkg::item_t item,
  input  wire fss_pkg::cfg_t  cfg,
  output fss_pkg::result_t result
);

  logic       power_on,       power_on_next;
  logic [1:0] speed_level,    speed_level_next;
  logic [2:0] hours_count,    hours_count_next;
  logic [7:0] tick_count,     tick_count_next;
  logic [5:0] second_count,   second_count_next;
  logic [5:0] minute_count,   minute_count_next;
  logic       power_btn_held, power_btn_held_next;
  logic       timer_btn_held, timer_btn_held_next;

  logic [8:0] tick_inc;
  logic [5:0] sec_inc;
  logic [5:0] min_inc;
  logic [3:0] hours_inc;
  logic [7:0] duty;

  always_comb begin
    power_on_next       = power_on;
    speed_level_next    = speed_level;
    hours_count_next    = hours_count;
    tick_count_next     = tick_count;
    second_count_next   = second_count;
    minute_count_next   = minute_count;
    power_btn_held_next = item.btn_power;
    timer_btn_held_next = timer_btn_held;

    tick_inc  = {1'b0, tick_count} + 9'd1;
    sec_inc   = second_count + 6'd1;
    min_inc   = minute_count + 6'd1;
    hours_inc = 4'd0;

    // advance the timer chain only while the sleep timer runs
    if (item.tick && (hours_count != 3'd0)) begin
      if (tick_inc < {1'b0, cfg.ticks_per_second}) begin
        tick_count_next = tick_inc[7:0];
      end else begin
        tick_count_next = 8'd0;
        if (sec_inc < fss_pkg::UNITS_PER_NEXT) begin
          second_count_next = sec_inc;
        end else begin
          second_count_next = 6'd0;
          if (min_inc < fss_pkg::UNITS_PER_NEXT) begin
            minute_count_next = min_inc;
          end else begin
            minute_count_next = 6'd0;
            hours_count_next  = hours_count - 3'd1;
            if (hours_count_next == 3'd0) begin
              power_on_next    = 1'b0;
              speed_level_next = fss_pkg::LEVEL_OFF;
            end
          end
        end
      end
    end

    // drop pending hours once the fan is off (power state after the timer update)
    if (!power_on_next) begin
      hours_count_next = 3'd0;
    end

    if (item.btn_power && !power_btn_held) begin
      power_on_next    = ~power_on_next;
      speed_level_next = fss_pkg::LEVEL_OFF;
    end

    if (power_on_next) begin
      if (item.btn_speed1) begin
        speed_level_next = fss_pkg::LEVEL_1;
      end else if (item.btn_speed2) begin
        speed_level_next = fss_pkg::LEVEL_2;
      end else if (item.btn_speed3) begin
        speed_level_next = fss_pkg::LEVEL_3;
      end

      if (item.btn_timer && !timer_btn_held) begin
        hours_inc = {1'b0, hours_count_next} + 4'd1;
        if (hours_inc > {1'b0, cfg.max_hours}) begin
          hours_count_next = 3'd0;
        end else begin
          hours_count_next = hours_inc[2:0];
        end
      end
      timer_btn_held_next = item.btn_timer;
    end

    case (speed_level_next)
      fss_pkg::LEVEL_1: duty = cfg.duty_level1;
      fss_pkg::LEVEL_2: duty = cfg.duty_level2;
      fss_pkg::LEVEL_3: duty = cfg.duty_level3;
      default:          duty = 8'd0;
    endcase

    result.fan_on     = power_on_next;
    result.fan_level  = speed_level_next;
    result.pwm_duty   = duty;
    result.hours_left = hours_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on       <= 1'b0;
      speed_level    <= fss_pkg::LEVEL_OFF;
      hours_count    <= 3'd0;
      tick_count     <= 8'd0;
      second_count   <= 6'd0;
      minute_count   <= 6'd0;
      power_btn_held <= 1'b0;
      timer_btn_held <= 1'b0;
    end else if (step) begin
      power_on       <= power_on_next;
      speed_level    <= speed_level_next;
      hours_count    <= hours_count_next;
      tick_count     <= tick_count_next;
      second_count   <= second_count_next;
      minute_count   <= minute_count_next;
      power_btn_held <= power_btn_held_next;
      timer_btn_held <= timer_btn_held_next;
    end
  end

endmodule

`default_nettype wire

@@ src/fan_speed_sleep_timer.sv @@
// Fan speed controller with sleep timer, top level.
//
// Item channel (item_valid, item_stall, item): one beat carries an optional
// timebase tick and the debounced levels of five buttons. Result channel
// (result_valid, result_stall, result): one beat per item with fan on flag,
// speed level, PWM compare value and remaining sleep hours after that item.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
// one register by index; cfg_ready is always high. Write only while idle.
//
// An item lands in an input register, the state update runs in combinational
// logic, and the result lands in the output register: result_valid rises when
// the output register takes the result. One item per cycle is sustained; the
// input register only holds while the output register is full and stalled.
// item_stall rises when both registers are full and result_stall is high.
//
// Synchronous reset (rst) clears the controller state, empties both
// registers and loads the configuration defaults.
// Depends on fss_pkg, fss_cfg and fss_core.
`default_nettype none

module fan_speed_sleep_timer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output      logic                              item_stall,
  input  wire fss_pkg::item_t                    item,
  output      logic                              result_valid,
  input  wire logic                              result_stall,
  output fss_pkg::result_t                       result,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [fss_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [fss_pkg::CfgDataWidth-1:0]  cfg_data
);

  fss_pkg::cfg_t    cfg;
  fss_pkg::item_t   item_q;
  fss_pkg::result_t result_next;
  logic             item_q_valid;
  logic             step;
  logic             item_accept;

  assign cfg_ready   = 1'b1;
  // move the held beat forward whenever the output register can take it
  assign step        = item_q_valid && !(result_valid && result_stall);
  assign item_stall  = item_q_valid && !step;
  assign item_accept = item_valid && !item_stall;

  fss_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fss_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item_q),
    .cfg    (cfg),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_accept) begin
        item_q_valid <= 1'b1;
      end else if (step) begin
        item_q_valid <= 1'b0;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (item_accept) begin
      item_q <= item;
    end
    if (step) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
